// ----- rtl/tcw_pkg.sv -----
// text console writer package: sizes, codes and the store command type
package tcw_pkg;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int CELLS     = COLUMNS * ROWS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int ROW_ADV_W = ROW_W + 2;
   localparam int CELL_W    = 16;
   localparam int SCROLL_W  = 2;
   localparam int TAB_STEP  = 4;

   localparam logic [1:0] MODE_PUT       = 2'd0;
   localparam logic [1:0] MODE_BACKSPACE = 2'd1;
   localparam logic [1:0] MODE_CLEAR     = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   localparam logic [7:0] BLANK_ATTR_RESET = 8'd15;

   typedef struct packed {
      logic                valid;
      logic                write_en;
      logic [ADDR_W-1:0]   addr;
      logic [CELL_W-1:0]   data;
      logic [SCROLL_W-1:0] scroll_rows;
      logic                clear;
   } store_cmd_type;

endpackage

// ----- rtl/tcw_channels_if.sv -----
// handshake channel interfaces for request, response and register write
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] char_code;
   logic [7:0] attribute;
   logic       use_position;
   logic [6:0] column;
   logic [4:0] row;

   modport source (output valid, mode, char_code, attribute, use_position, column, row,
                   input ready);
   modport sink (input valid, mode, char_code, attribute, use_position, column, row,
                 output ready);
endinterface

interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cursor_offset;
   logic        scrolled;

   modport source (output valid, cursor_offset, scrolled, input ready);
   modport sink (input valid, cursor_offset, scrolled, output ready);
endinterface

interface tcw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] blank_attribute;

   modport source (output valid, blank_attribute, input ready);
   modport sink (input valid, blank_attribute, output ready);
endinterface

// ----- rtl/tcw_cursor.sv -----
// cursor register and per-item position update, issues store commands
module tcw_cursor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            mode,
   input  logic [7:0]            char_code,
   input  logic [7:0]            attribute,
   input  logic                  use_position,
   input  logic [6:0]            column,
   input  logic [4:0]            row,
   input  logic [7:0]            blank_attribute,
   output tcw_pkg::store_cmd_type cmd_out,
   output logic [10:0]           cursor_offset,
   output logic                  scrolled
);
   import tcw_pkg::*;

   logic [COL_W-1:0]     cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]     cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]     col_base, col_n;
   logic [ROW_ADV_W-1:0] row_base, row_n;
   logic [ADDR_W-1:0]    offset_n;
   store_cmd_type        cmd;
   logic                 scroll_n;

   always_comb begin
      if (use_position) begin
         col_base = (32'(column) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(column);
         row_base = (32'(row) > ROWS - 1) ? ROW_ADV_W'(ROWS - 1) : ROW_ADV_W'(row);
      end else begin
         col_base = cursor_col_ff;
         row_base = ROW_ADV_W'(cursor_row_ff);
      end

      col_n    = cursor_col_ff;
      row_n    = ROW_ADV_W'(cursor_row_ff);
      scroll_n = 1'b0;
      cmd      = '0;
      cmd.valid = accept;

      case (mode)
         MODE_PUT: begin
            col_n    = col_base;
            row_n    = row_base;
            cmd.addr = ADDR_W'(row_base) * ADDR_W'(COLUMNS) + ADDR_W'(col_base);
            if (char_code == CHAR_NEWLINE) begin
               col_n = '0;
               row_n = row_n + 1'b1;
            end else if (char_code == CHAR_TAB) begin
               for (int k = 0; k < TAB_STEP; k++) begin
                  if (col_n == COL_W'(COLUMNS - 1)) begin
                     col_n = '0;
                     row_n = row_n + 1'b1;
                  end else begin
                     col_n = col_n + 1'b1;
                  end
               end
            end else begin
               cmd.write_en = 1'b1;
               cmd.data     = {attribute, char_code};
               if (col_n == COL_W'(COLUMNS - 1)) begin
                  col_n = '0;
                  row_n = row_n + 1'b1;
               end else begin
                  col_n = col_n + 1'b1;
               end
            end
            if (row_n >= ROW_ADV_W'(ROWS)) begin
               scroll_n        = 1'b1;
               cmd.scroll_rows = SCROLL_W'(row_n - ROW_ADV_W'(ROWS - 1));
               row_n           = ROW_ADV_W'(ROWS - 1);
            end
         end
         MODE_BACKSPACE: begin
            if (cursor_col_ff != '0) begin
               col_n = cursor_col_ff - 1'b1;
            end else if (cursor_row_ff != '0) begin
               col_n = COL_W'(COLUMNS - 1);
               row_n = ROW_ADV_W'(cursor_row_ff) - 1'b1;
            end
            cmd.write_en = 1'b1;
            cmd.addr     = ADDR_W'(row_n) * ADDR_W'(COLUMNS) + ADDR_W'(col_n);
            cmd.data     = {blank_attribute, CHAR_SPACE};
         end
         MODE_CLEAR: begin
            col_n     = '0;
            row_n     = '0;
            cmd.clear = 1'b1;
         end
         default: begin
         end
      endcase

      offset_n      = ADDR_W'(row_n) * ADDR_W'(COLUMNS) + ADDR_W'(col_n);
      cursor_col_in = accept ? col_n : cursor_col_ff;
      cursor_row_in = accept ? ROW_W'(row_n) : cursor_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   assign cmd_out       = cmd;
   assign cursor_offset = 11'(offset_n);
   assign scrolled      = scroll_n;

endmodule

// ----- rtl/tcw_cell_store.sv -----
// screen cell memory with single writes and sweeps for init, scroll and clear
module tcw_cell_store (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::store_cmd_type cmd_in,
   input  logic [7:0]            blank_attribute,
   output logic                  busy
);
   import tcw_pkg::*;

   localparam int KEEP = CELLS - COLUMNS;

   typedef enum logic [3:0] {
      ST_INIT   = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCROLL = 4'b0100,
      ST_CLEAR  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      KIND_COPY,
      KIND_BLANK,
      KIND_MASK,
      KIND_ZERO
   } kind_type;

   logic [CELL_W-1:0]   mem [CELLS];
   logic [CELL_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CELL_W-1:0]   wr_data;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [SCROLL_W-1:0] scroll_left_ff, scroll_left_in;
   logic                pipe_valid_ff, pipe_valid_in;
   logic [ADDR_W-1:0]   pipe_addr_ff, pipe_addr_in;
   kind_type            pipe_kind_ff, pipe_kind_in;
   logic                sweeping;
   logic                last_idx;

   assign sweeping = (state_ff == ST_INIT) || (state_ff == ST_SCROLL) ||
                     (state_ff == ST_CLEAR);
   assign last_idx = (idx_ff == ADDR_W'(CELLS - 1));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      scroll_left_in = scroll_left_ff;
      pipe_valid_in  = 1'b0;
      pipe_addr_in   = idx_ff;
      pipe_kind_in   = KIND_ZERO;
      rd_addr        = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_in.valid && cmd_in.scroll_rows != '0) begin
               state_in       = ST_SCROLL;
               scroll_left_in = cmd_in.scroll_rows;
               idx_in         = '0;
            end else if (cmd_in.valid && cmd_in.clear) begin
               state_in = ST_CLEAR;
               idx_in   = '0;
            end
         end
         ST_INIT: begin
            pipe_valid_in = 1'b1;
            pipe_kind_in  = KIND_ZERO;
         end
         ST_SCROLL: begin
            pipe_valid_in = 1'b1;
            if (idx_ff < ADDR_W'(KEEP)) begin
               rd_addr      = idx_ff + ADDR_W'(COLUMNS);
               pipe_kind_in = KIND_COPY;
            end else begin
               pipe_kind_in = KIND_BLANK;
            end
         end
         ST_CLEAR: begin
            pipe_valid_in = 1'b1;
            pipe_kind_in  = KIND_MASK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (sweeping) begin
         if (last_idx) begin
            idx_in = '0;
            if (state_ff == ST_SCROLL && scroll_left_ff > SCROLL_W'(1)) begin
               scroll_left_in = scroll_left_ff - 1'b1;
            end else begin
               state_in       = ST_IDLE;
               scroll_left_in = '0;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmd_in.addr;
      wr_data = cmd_in.data;
      if (pipe_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = pipe_addr_ff;
         case (pipe_kind_ff)
            KIND_COPY:  wr_data = rd_data_ff;
            KIND_BLANK: wr_data = {blank_attribute, CHAR_SPACE};
            KIND_MASK:  wr_data = {rd_data_ff[15:8], 8'h00};
            default:    wr_data = '0;
         endcase
      end else if (cmd_in.valid && cmd_in.write_en) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         idx_ff         <= '0;
         scroll_left_ff <= '0;
         pipe_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         scroll_left_ff <= scroll_left_in;
         pipe_valid_ff  <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_addr_ff <= pipe_addr_in;
      pipe_kind_ff <= pipe_kind_in;
   end

   assign busy = (state_ff != ST_IDLE) || pipe_valid_ff;

`ifndef NO_ASSERTIONS
   a_cmd_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_in.valid |-> (state_ff == ST_IDLE && !pipe_valid_ff))
      else $error("store command while sweep in progress");

   a_pipe_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      pipe_valid_ff |-> (pipe_addr_ff < ADDR_W'(CELLS)))
      else $error("sweep write beyond store");

   a_scroll_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cmd_in.valid && cmd_in.scroll_rows != '0)
      |=> (state_ff == ST_SCROLL && busy))
      else $error("scroll command did not start sweep");
`endif

endmodule

// ----- rtl/text_console_writer.sv -----
// text console writer top level: 80x25 cell store, cursor and handshakes
// response: registered, valid in the cycle after the item is taken
// throughput: put and backspace one item per cycle while the response side keeps up; a scroll
//   (one row at most) or a clear screen holds off the next item until the store sweep and its write stage are done
// reset: cursor to zero, blank attribute to 15, then a clearing pass of the
//   cell store during which no item is taken; register writes are taken throughout
module text_console_writer (
   input logic      clock,
   input logic      reset,
   tcw_req_if.sink  req_if,
   tcw_rsp_if.source rsp_if,
   tcw_csr_if.sink  csr_if
);
   import tcw_pkg::*;

   logic          accept;
   logic          store_busy;
   store_cmd_type cmd;
   logic [10:0]   offset_n;
   logic          scrolled_n;

   logic [7:0]    blank_attr_ff, blank_attr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [10:0]   rsp_offset_ff, rsp_offset_in;
   logic          rsp_scrolled_ff, rsp_scrolled_in;

   assign req_if.ready = !store_busy && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   tcw_cursor u_cursor (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .mode            (req_if.mode),
      .char_code       (req_if.char_code),
      .attribute       (req_if.attribute),
      .use_position    (req_if.use_position),
      .column          (req_if.column),
      .row             (req_if.row),
      .blank_attribute (blank_attr_ff),
      .cmd_out         (cmd),
      .cursor_offset   (offset_n),
      .scrolled        (scrolled_n)
   );

   tcw_cell_store u_store (
      .clock           (clock),
      .reset           (reset),
      .cmd_in          (cmd),
      .blank_attribute (blank_attr_ff),
      .busy            (store_busy)
   );

   always_comb begin
      blank_attr_in   = (csr_if.valid && csr_if.ready) ? csr_if.blank_attribute
                                                       : blank_attr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_offset_in   = rsp_offset_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      if (accept) begin
         rsp_valid_in    = 1'b1;
         rsp_offset_in   = offset_n;
         rsp_scrolled_in = scrolled_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= BLANK_ATTR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         blank_attr_ff <= blank_attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_ff   <= rsp_offset_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cursor_offset = rsp_offset_ff;
   assign rsp_if.scrolled      = rsp_scrolled_ff;

endmodule

// ----- sim/text_console_writer_tb.sv -----
// self-checking testbench for the text console writer: directed table, random text, cursor check
`timescale 1ns / 100ps

module text_console_writer_tb;
   import tcw_pkg::*;

   localparam logic [1:0] MODE_UNUSED      = 2'd3;
   localparam logic [7:0] CHAR_RETURN      = 8'd13;
   localparam int         RANDOM_PER_PHASE = 260;
   localparam int         LONG_HOLD        = 400;
   localparam int         SWEEP_SETTLE     = CELLS + 16;
   localparam int         IDLE_LIMIT       = 10 * CELLS;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [7:0] attribute;
      logic       use_position;
      logic [6:0] column;
      logic [4:0] row;
   } text_cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] cursor_offset;
      logic              scrolled;
   } cursor_result_type;

   typedef struct packed {
      text_cmd_type      cmd;
      logic              fixed;
      cursor_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();
   tcw_csr_if csr_if ();

   text_console_writer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #6 clock = ~clock;

   logic [CELL_W-1:0] screen_model [CELLS];
   int unsigned       cursor_model;
   logic [7:0]        blank_attr_model;

   cursor_result_type pending_cursor_q [$];
   int unsigned    error_count;
   int unsigned    items_sent;
   int unsigned    scroll_count;
   int unsigned    clear_count;
   int unsigned    attr_writes;
   int unsigned    sender_gap_pct;
   int unsigned    recv_stall_pct;
   bit             hold_start;

   directed_row_type script [21] = '{
      '{'{MODE_BACKSPACE, 8'h00, 8'h00, 1'b0, 7'd0,   5'd0},  1'b1, '{11'd0,    1'b0}},
      '{'{MODE_PUT,       8'd65, 8'h00, 1'b0, 7'd0,   5'd0},  1'b1, '{11'd1,    1'b0}},
      '{'{MODE_PUT, CHAR_RETURN, 8'hFF, 1'b0, 7'd127, 5'd31}, 1'b1, '{11'd2,    1'b0}},
      '{'{MODE_PUT,    CHAR_TAB, 8'h55, 1'b0, 7'd0,   5'd0},  1'b1, '{11'd6,    1'b0}},
      '{'{MODE_PUT, CHAR_NEWLINE, 8'hAA, 1'b0, 7'd0,  5'd0},  1'b1, '{11'd80,   1'b0}},
      '{'{MODE_UNUSED,    8'hFF, 8'hFF, 1'b1, 7'd5,   5'd5},  1'b1, '{11'd80,   1'b0}},
      '{'{MODE_PUT,       8'h00, 8'h00, 1'b1, 7'd79,  5'd24}, 1'b1, '{11'd1920, 1'b1}},
      '{'{MODE_PUT,       8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31}, 1'b1, '{11'd1920, 1'b1}},
      '{'{MODE_PUT,       8'hFF, 8'h80, 1'b1, 7'd0,   5'd0},  1'b0, '0},
      '{'{MODE_BACKSPACE, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31}, 1'b0, '0},
      '{'{MODE_PUT,    CHAR_TAB, 8'h01, 1'b1, 7'd78,  5'd24}, 1'b0, '0},
      '{'{MODE_PUT, CHAR_NEWLINE, 8'h02, 1'b0, 7'd0,  5'd0},  1'b0, '0},
      '{'{MODE_PUT, CHAR_NEWLINE, 8'h03, 1'b1, 7'd100, 5'd3}, 1'b0, '0},
      '{'{MODE_PUT,       8'h7F, 8'h04, 1'b0, 7'd0,   5'd0},  1'b0, '0},
      '{'{MODE_CLEAR,     8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31}, 1'b1, '{11'd0,    1'b0}},
      '{'{MODE_BACKSPACE, 8'h00, 8'h00, 1'b0, 7'd0,   5'd0},  1'b1, '{11'd0,    1'b0}},
      '{'{MODE_UNUSED,    8'h00, 8'h00, 1'b0, 7'd0,   5'd0},  1'b0, '0},
      '{'{MODE_PUT, CHAR_NEWLINE, 8'h10, 1'b1, 7'd0,  5'd24}, 1'b0, '0},
      '{'{MODE_PUT,    CHAR_TAB, 8'h20, 1'b1, 7'd79,  5'd0},  1'b0, '0},
      '{'{MODE_PUT,       8'h80, 8'h7F, 1'b0, 7'd64,  5'd16}, 1'b0, '0},
      '{'{MODE_PUT, CHAR_NEWLINE, 8'h40, 1'b1, 7'd80, 5'd25}, 1'b0, '0}
   };

   function automatic cursor_result_type advance_console(input text_cmd_type c);
      cursor_result_type res;
      int unsigned    pos, col_sel, row_sel, up, keep;
      res.scrolled = 1'b0;
      case (c.mode)
         MODE_PUT: begin
            col_sel = (32'(c.column) > COLUMNS - 1) ? COLUMNS - 1 : 32'(c.column);
            row_sel = (32'(c.row) > ROWS - 1) ? ROWS - 1 : 32'(c.row);
            pos = c.use_position ? row_sel * COLUMNS + col_sel : cursor_model;
            if (c.char_code == CHAR_NEWLINE) begin
               pos = (pos / COLUMNS + 1) * COLUMNS;
            end else if (c.char_code == CHAR_TAB) begin
               pos += TAB_STEP;
            end else begin
               screen_model[pos] = {c.attribute, c.char_code};
               pos += 1;
            end
            if (pos >= CELLS) begin
               res.scrolled = 1'b1;
               up = (pos - CELLS) / COLUMNS + 1;
               if (up > ROWS) up = ROWS;
               keep = CELLS - up * COLUMNS;
               for (int i = 0; i < keep; i++) screen_model[i] = screen_model[i + up * COLUMNS];
               for (int i = keep; i < CELLS; i++) screen_model[i] = {blank_attr_model, CHAR_SPACE};
               pos -= up * COLUMNS;
               if (pos >= CELLS) pos = CELLS - 1;
            end
            cursor_model = pos;
         end
         MODE_BACKSPACE: begin
            pos = (cursor_model == 0) ? 0 : cursor_model - 1;
            screen_model[pos] = {blank_attr_model, CHAR_SPACE};
            cursor_model = pos;
         end
         MODE_CLEAR: begin
            foreach (screen_model[i]) screen_model[i][7:0] = 8'h00;
            cursor_model = 0;
         end
         default: begin
         end
      endcase
      res.cursor_offset = cursor_model[ADDR_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < 100)
         $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic offer_command(input text_cmd_type cmd, input bit fixed,
                                input cursor_result_type fixed_result);
      cursor_result_type res;
      if ($urandom_range(99) < sender_gap_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_if.valid        <= 1'b1;
      req_if.mode         <= cmd.mode;
      req_if.char_code    <= cmd.char_code;
      req_if.attribute    <= cmd.attribute;
      req_if.use_position <= cmd.use_position;
      req_if.column       <= cmd.column;
      req_if.row          <= cmd.row;
      do @(posedge clock); while (!req_if.ready);
      res = advance_console(cmd);
      pending_cursor_q.push_back(fixed ? fixed_result : res);
      if (res.scrolled) scroll_count++;
      if (cmd.mode == MODE_CLEAR) clear_count++;
      items_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_cursor_q.size() != 0) @(posedge clock);
   endtask

   // the store sweep of a scroll or clear may still run after its item has come back
   task automatic set_blank_attribute(input logic [7:0] attr);
      drain_results();
      repeat (SWEEP_SETTLE) @(posedge clock);
      csr_if.valid           <= 1'b1;
      csr_if.blank_attribute <= attr;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      blank_attr_model = attr;
      attr_writes++;
   endtask

   initial begin
      int unsigned hold_left;
      bit          hold_taken;
      hold_left     = 0;
      hold_taken    = 1'b0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cursor_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_cursor_q.size() == 0) begin
            report_mismatch("unrequested item, cursor", 32'(rsp_if.cursor_offset), 0);
         end else begin
            want = pending_cursor_q.pop_front();
            if (rsp_if.cursor_offset !== want.cursor_offset)
               report_mismatch("cursor_offset", 32'(rsp_if.cursor_offset),
                               32'(want.cursor_offset));
            if (rsp_if.scrolled !== want.scrolled)
               report_mismatch("scrolled", 32'(rsp_if.scrolled), 32'(want.scrolled));
         end
      end
   end

   initial begin
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      text_cmd_type cmd;
      int unsigned  sel;
      req_if.valid           = 1'b0;
      req_if.mode            = MODE_PUT;
      req_if.char_code       = 8'h00;
      req_if.attribute       = 8'h00;
      req_if.use_position    = 1'b0;
      req_if.column          = 7'd0;
      req_if.row             = 5'd0;
      csr_if.valid           = 1'b0;
      csr_if.blank_attribute = 8'h00;
      hold_start             = 1'b0;
      error_count            = 0;
      items_sent             = 0;
      scroll_count           = 0;
      clear_count            = 0;
      attr_writes            = 0;
      cursor_model           = 0;
      blank_attr_model       = BLANK_ATTR_RESET;
      foreach (screen_model[i]) screen_model[i] = '0;
      sender_gap_pct         = 29;
      recv_stall_pct         = 67;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_blank_attribute(8'h00);
      foreach (script[i]) offer_command(script[i].cmd, script[i].fixed, script[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_gap_pct = 29;
               recv_stall_pct = 67;
               set_blank_attribute(8'hFF);
            end
            1: begin
               sender_gap_pct = 67;
               recv_stall_pct = 29;
               set_blank_attribute(8'($urandom_range(254, 1)));
            end
            default: begin
               sender_gap_pct = 0;
               recv_stall_pct = 0;
               set_blank_attribute(BLANK_ATTR_RESET);
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 1 && n == RANDOM_PER_PHASE / 2) drain_results();
            if (phase == 2 && n == RANDOM_PER_PHASE / 3) hold_start <= 1'b1;
            cmd.mode         = MODE_PUT;
            cmd.char_code    = 8'($urandom_range(255));
            cmd.attribute    = 8'($urandom_range(255));
            cmd.use_position = 1'b0;
            cmd.column       = 7'($urandom_range(127));
            cmd.row          = 5'($urandom_range(31));
            sel = $urandom_range(99);
            if (sel < 70) begin
               // running text at the cursor
               sel = $urandom_range(99);
               if (sel < 9)
                  cmd.char_code = CHAR_NEWLINE;
               else if (sel < 15)
                  cmd.char_code = CHAR_TAB;
               else if (sel < 18)
                  cmd.char_code = CHAR_RETURN;
            end else if (sel < 84) begin
               cmd.use_position = 1'b1;
               if ($urandom_range(3) == 0) begin
                  // aim at the last row, often past its end
                  cmd.row    = 5'($urandom_range(31, ROWS - 1));
                  cmd.column = 7'($urandom_range(127, COLUMNS - 4));
               end
               if ($urandom_range(3) == 0)
                  cmd.char_code = $urandom_range(1) ? CHAR_NEWLINE : CHAR_TAB;
            end else if (sel < 96) begin
               cmd.mode = MODE_BACKSPACE;
            end else if (sel < 98) begin
               cmd.mode = MODE_CLEAR;
            end else begin
               cmd.mode = MODE_UNUSED;
            end
            offer_command(cmd, 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("%0d items sent, %0d directed; %0d scrolls and %0d clears predicted",
               items_sent, $size(script), scroll_count, clear_count);
      $display("blank attribute written %0d times; %0d mismatches", attr_writes, error_count);
      if (error_count == 0 && pending_cursor_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
